FILE: sv/dhbd_pkg.sv
package dhbd_pkg;

    localparam int DEF_LEVELS            = 3;
    localparam int DEF_ANCHORS_PER_LEVEL = 3;
    localparam int DEF_MAX_CLASSES       = 128;

    localparam logic [2:0] REG_NUM_CLASSES     = 3'd0;
    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_NET_WIDTH       = 3'd2;
    localparam logic [2:0] REG_NET_HEIGHT      = 3'd3;
    localparam logic [2:0] REG_GRID_DIMS       = 3'd4;
    localparam logic [2:0] REG_ANCHORS_LEVEL0  = 3'd5;
    localparam logic [2:0] REG_ANCHORS_LEVEL1  = 3'd6;
    localparam logic [2:0] REG_ANCHORS_LEVEL2  = 3'd7;

    localparam logic [7:0]  RST_NUM_CLASSES = 8'd80;
    localparam logic [15:0] RST_THRESHOLD   = 16'd16384;
    localparam logic [11:0] RST_NET_SIZE    = 12'd640;
    localparam logic [47:0] RST_GRID_DIMS   = 48'd22003043352620;

    localparam int DIV_BITS  = 26;
    localparam int OUT_BYTES = 17;

    localparam logic signed [28:0] EDGE_MAX = 29'sd131071;
    localparam logic signed [28:0] EDGE_MIN = -29'sd131072;

    typedef logic signed [17:0] edge_t;

    function automatic edge_t sat_edge(input logic signed [28:0] v);
        if (v > EDGE_MAX) begin
            return edge_t'(EDGE_MAX);
        end else if (v < EDGE_MIN) begin
            return edge_t'(EDGE_MIN);
        end
        return edge_t'(v);
    endfunction

endpackage

FILE: sv/detection_head_box_decode.sv
// detector head box decode
// s_ channel: one head element per transaction, s_tdata = head_value,
// s_tuser = frame_start (clears all position counters before the value is taken).
// cfg channel: register writes by index, ready whenever out of reset; write only while idle.
// m_ channel: one detection per row whose score reaches the threshold.
// an element that does not end a kept row does not stall the input, so rows stream
// at one element per cycle. the last element of a kept row holds s_tready low
// until the result is loaded: one shared multiplier and one restoring divider
// (26-bit quotient per coordinate) work through the centre and size math in turn.
// the result sits in an output register; input is taken again once it is
// loaded, so a stalled receiver only blocks when a second detection is ready.
// reset (aresetn low, synchronous) restores register defaults, clears the element
// and position counters, the row accumulators and the state machine, and drops m_tvalid.
module detection_head_box_decode #(
    parameter int LEVELS            = dhbd_pkg::DEF_LEVELS,
    parameter int ANCHORS_PER_LEVEL = dhbd_pkg::DEF_ANCHORS_PER_LEVEL,
    parameter int MAX_CLASSES       = dhbd_pkg::DEF_MAX_CLASSES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,  // head_value
    input  logic [0:0]   s_tuser,  // frame_start
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    // class_id, score, x_min, y_min, box_width, box_height, x_max, y_max, zero pad
    output logic [dhbd_pkg::OUT_BYTES*8-1:0] m_tdata
);
    import dhbd_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MX   = 4'd1;
    localparam logic [3:0] ST_NX   = 4'd2;
    localparam logic [3:0] ST_DX   = 4'd3;
    localparam logic [3:0] ST_MY   = 4'd4;
    localparam logic [3:0] ST_NY   = 4'd5;
    localparam logic [3:0] ST_DY   = 4'd6;
    localparam logic [3:0] ST_W1   = 4'd7;
    localparam logic [3:0] ST_W2   = 4'd8;
    localparam logic [3:0] ST_H1   = 4'd9;
    localparam logic [3:0] ST_H2   = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    localparam logic [2:0] LEVELS_C  = 3'(LEVELS);
    localparam logic [2:0] ANCHORS_C = 3'(ANCHORS_PER_LEVEL);
    localparam logic [7:0] MAXC_C    = 8'(MAX_CLASSES);

    logic [7:0]  num_classes_reg;
    logic [15:0] threshold_reg;
    logic [11:0] net_width_reg, net_height_reg;
    logic [47:0] grid_dims_reg;
    logic [59:0] anc0_reg, anc1_reg, anc2_reg;

    logic [7:0]  elem_reg;
    logic [15:0] box_raw_reg [4];
    logic [15:0] obj_reg, best_reg;
    logic [6:0]  best_idx_reg;
    logic [7:0]  col_reg, row_reg;
    logic [1:0]  anchor_reg, level_reg;

    logic [3:0]  state_reg;
    logic [7:0]  gw_snap_reg, gh_snap_reg, col_snap_reg, row_snap_reg;
    logic [9:0]  aw_snap_reg, ah_snap_reg;
    logic [15:0] score_reg;
    logic [6:0]  class_reg;
    logic signed [52:0] prod_reg;
    logic [DIV_BITS-1:0] dq_reg;
    logic [7:0]  dr_reg;
    logic        neg_reg;
    logic [4:0]  cnt_reg;
    logic signed [27:0] px_reg, py_reg;
    logic [16:0] wq_reg;
    logic [15:0] hw_reg;

    logic        m_valid_reg;
    logic [OUT_BYTES*8-1:0] m_data_reg;

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // input side
    logic        acc, fs;
    logic [7:0]  nc, last, e_raw, e;
    logic [7:0]  col_e, row_e;
    logic [1:0]  anc_e, lvl_e;
    logic [7:0]  gw_cur, gh_cur, gw_f, gh_f;
    logic [59:0] anc_sel;
    logic [19:0] pair;
    logic [15:0] best_next;
    logic [6:0]  idx_next;
    logic [31:0] score_full;
    logic        row_end, emit;
    logic [8:0]  col_inc, row_inc;
    logic [2:0]  anc_inc, lvl_inc;

    always_comb begin
        acc = s_tvalid && s_tready;
        fs  = s_tuser[0];
        nc  = num_classes_reg;
        if (nc == 8'd0) begin
            nc = 8'd1;
        end else if (nc > MAXC_C) begin
            nc = MAXC_C;
        end
        last  = nc + 8'd4;
        e_raw = fs ? 8'd0 : elem_reg;
        e     = (e_raw > last) ? last : e_raw;
        col_e = fs ? 8'd0 : col_reg;
        row_e = fs ? 8'd0 : row_reg;
        anc_e = fs ? 2'd0 : anchor_reg;
        lvl_e = fs ? 2'd0 : level_reg;

        gw_f = 8'd0;
        gh_f = 8'd0;
        anc_sel = '0;
        unique case (lvl_e)
            2'd0: begin
                gw_f = grid_dims_reg[7:0];
                gh_f = grid_dims_reg[15:8];
                anc_sel = anc0_reg;
            end
            2'd1: begin
                gw_f = grid_dims_reg[23:16];
                gh_f = grid_dims_reg[31:24];
                anc_sel = anc1_reg;
            end
            2'd2: begin
                gw_f = grid_dims_reg[39:32];
                gh_f = grid_dims_reg[47:40];
                anc_sel = anc2_reg;
            end
            default: begin
                gw_f = 8'd0;
                gh_f = 8'd0;
                anc_sel = '0;
            end
        endcase
        gw_cur = (gw_f == 8'd0) ? 8'd1 : gw_f;
        gh_cur = (gh_f == 8'd0) ? 8'd1 : gh_f;
        unique case (anc_e)
            2'd0:    pair = anc_sel[19:0];
            2'd1:    pair = anc_sel[39:20];
            2'd2:    pair = anc_sel[59:40];
            default: pair = 20'd0;
        endcase

        best_next = best_reg;
        idx_next  = best_idx_reg;
        if (e == 8'd5) begin
            best_next = s_tdata;
            idx_next  = 7'd0;
        end else if (e > 8'd5 && s_tdata > best_reg) begin
            best_next = s_tdata;
            idx_next  = 7'(e - 8'd5);
        end
        score_full = obj_reg * best_next;
        row_end = (e == last);
        emit    = row_end && (score_full[31:16] >= threshold_reg);

        col_inc = {1'b0, col_e} + 9'd1;
        row_inc = {1'b0, row_e} + 9'd1;
        anc_inc = {1'b0, anc_e} + 3'd1;
        lvl_inc = {1'b0, lvl_e} + 3'd1;
    end

    // shared multiplier
    logic signed [34:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [52:0] mul_p;
    logic [16:0] bw2, bh2;

    always_comb begin
        bw2 = {box_raw_reg[2], 1'b0};
        bh2 = {box_raw_reg[3], 1'b0};
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MX: begin
                mul_a = 35'({1'b0, box_raw_reg[0], 1'b0}) + 35'({col_snap_reg, 16'd0})
                        - 35'sd32768;
                mul_b = 18'({1'b0, net_width_reg});
            end
            ST_MY: begin
                mul_a = 35'({1'b0, box_raw_reg[1], 1'b0}) + 35'({row_snap_reg, 16'd0})
                        - 35'sd32768;
                mul_b = 18'({1'b0, net_height_reg});
            end
            ST_W1: begin
                mul_a = 35'({1'b0, bw2});
                mul_b = 18'({1'b0, bw2});
            end
            ST_W2: begin
                mul_a = 35'(prod_reg[33:0]);
                mul_b = 18'({1'b0, aw_snap_reg});
            end
            ST_H1: begin
                mul_a = 35'({1'b0, bh2});
                mul_b = 18'({1'b0, bh2});
            end
            ST_H2: begin
                mul_a = 35'(prod_reg[33:0]);
                mul_b = 18'({1'b0, ah_snap_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // divider step and normalize
    logic [7:0]  div_g;
    logic [8:0]  dr_sh;
    logic        ge;
    logic [8:0]  dr_step;
    logic [DIV_BITS-1:0] dq_step;
    logic signed [27:0] div_res;
    logic signed [40:0] num_sh;
    logic [DIV_BITS-1:0] num_mag;
    logic        num_neg;

    always_comb begin
        div_g   = (state_reg == ST_DX) ? gw_snap_reg : gh_snap_reg;
        dr_sh   = {dr_reg, dq_reg[DIV_BITS-1]};
        ge      = dr_sh >= {1'b0, div_g};
        dr_step = ge ? dr_sh - {1'b0, div_g} : dr_sh;
        dq_step = {dq_reg[DIV_BITS-2:0], ge};
        if (neg_reg) begin
            div_res = -28'(dq_step) - ((dr_step != 9'd0) ? 28'sd1 : 28'sd0);
        end else begin
            div_res = 28'(dq_step);
        end
        num_sh  = prod_reg[52:12];
        num_neg = num_sh < 0;
        num_mag = num_neg ? DIV_BITS'(-num_sh) : DIV_BITS'(num_sh);
    end

    // output assembly
    logic [15:0] hh;
    logic [16:0] hq;
    edge_t x_min, y_min, x_max, y_max;

    always_comb begin
        hq    = (prod_reg[52:28] > 25'd131071) ? 17'd131071 : 17'(prod_reg[52:28]);
        hh    = 16'(prod_reg[52:29]);
        x_min = sat_edge(29'(px_reg) - 29'($signed({1'b0, hw_reg})));
        x_max = sat_edge(29'(px_reg) + 29'($signed({1'b0, hw_reg})));
        y_min = sat_edge(29'(py_reg) - 29'($signed({1'b0, hh})));
        y_max = sat_edge(29'(py_reg) + 29'($signed({1'b0, hh})));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg <= RST_NUM_CLASSES;
            threshold_reg   <= RST_THRESHOLD;
            net_width_reg   <= RST_NET_SIZE;
            net_height_reg  <= RST_NET_SIZE;
            grid_dims_reg   <= RST_GRID_DIMS;
            anc0_reg        <= '0;
            anc1_reg        <= '0;
            anc2_reg        <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NUM_CLASSES:     num_classes_reg <= cfg_data[7:0];
                REG_SCORE_THRESHOLD: threshold_reg   <= cfg_data[15:0];
                REG_NET_WIDTH:       net_width_reg   <= cfg_data[11:0];
                REG_NET_HEIGHT:      net_height_reg  <= cfg_data[11:0];
                REG_GRID_DIMS:       grid_dims_reg   <= cfg_data[47:0];
                REG_ANCHORS_LEVEL0:  anc0_reg        <= cfg_data[59:0];
                REG_ANCHORS_LEVEL1:  anc1_reg        <= cfg_data[59:0];
                REG_ANCHORS_LEVEL2:  anc2_reg        <= cfg_data[59:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_reg     <= '0;
            box_raw_reg  <= '{default: '0};
            obj_reg      <= '0;
            best_reg     <= '0;
            best_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            anchor_reg   <= '0;
            level_reg    <= '0;
        end else if (acc) begin
            if (e < 8'd4) begin
                box_raw_reg[e[1:0]] <= s_tdata;
            end
            if (e == 8'd4) begin
                obj_reg <= s_tdata;
            end
            best_reg     <= best_next;
            best_idx_reg <= idx_next;
            col_reg      <= col_e;
            row_reg      <= row_e;
            anchor_reg   <= anc_e;
            level_reg    <= lvl_e;
            if (!row_end) begin
                elem_reg <= e + 8'd1;
            end else begin
                elem_reg <= 8'd0;
                if (col_inc < {1'b0, gw_cur}) begin
                    col_reg <= col_inc[7:0];
                end else begin
                    col_reg <= 8'd0;
                    if (row_inc < {1'b0, gh_cur}) begin
                        row_reg <= row_inc[7:0];
                    end else begin
                        row_reg <= 8'd0;
                        if (anc_inc < ANCHORS_C) begin
                            anchor_reg <= anc_inc[1:0];
                        end else begin
                            anchor_reg <= 2'd0;
                            level_reg  <= (lvl_inc < LEVELS_C) ? lvl_inc[1:0] : 2'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (acc && emit) begin
                        state_reg    <= ST_MX;
                        gw_snap_reg  <= gw_cur;
                        gh_snap_reg  <= gh_cur;
                        col_snap_reg <= col_e;
                        row_snap_reg <= row_e;
                        aw_snap_reg  <= pair[9:0];
                        ah_snap_reg  <= pair[19:10];
                        score_reg    <= score_full[31:16];
                        class_reg    <= idx_next;
                    end
                end
                ST_MX, ST_MY, ST_W1, ST_W2, ST_H2: begin
                    prod_reg  <= mul_p;
                    state_reg <= state_reg + 4'd1;
                end
                ST_NX, ST_NY: begin
                    dq_reg    <= num_mag;
                    dr_reg    <= '0;
                    neg_reg   <= num_neg;
                    cnt_reg   <= '0;
                    state_reg <= state_reg + 4'd1;
                end
                ST_DX, ST_DY: begin
                    dq_reg  <= dq_step;
                    dr_reg  <= dr_step[7:0];
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_BITS - 1)) begin
                        if (state_reg == ST_DX) begin
                            px_reg <= div_res;
                        end else begin
                            py_reg <= div_res;
                        end
                        state_reg <= state_reg + 4'd1;
                    end
                end
                ST_H1: begin
                    wq_reg    <= hq;
                    hw_reg    <= hh;
                    prod_reg  <= mul_p;
                    state_reg <= ST_H2;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {7'd0, y_max, x_max, hq, wq_reg, y_min, x_min,
                                        score_reg, class_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dhbd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [6:0]         class_id;
        logic [15:0]        score;
        logic signed [17:0] x_min;
        logic signed [17:0] y_min;
        logic [16:0]        box_width;
        logic [16:0]        box_height;
        logic signed [17:0] x_max;
        logic signed [17:0] y_max;
    } detection_t;

    typedef struct {
        logic [15:0] value;
        bit          fs;
        bit          known;
        logic [6:0]  k_class;
        logic [15:0] k_score;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;   // head_value
    logic [0:0]   s_tuser = '0;   // frame_start
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // class_id, score, x_min, y_min, box_width, box_height, x_max, y_max, zero pad
    logic [OUT_BYTES*8-1:0] m_tdata;

    detection_head_box_decode u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    detection_t pending_dets[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;

    // decoder shadow state
    int unsigned nc_reg = 80, thr_reg = 16384, netw_reg = 640, neth_reg = 640;
    longint unsigned grid_reg = 48'd22003043352620;
    longint unsigned anc_reg[3] = '{0, 0, 0};
    int unsigned elem_idx = 0, box_raw[4] = '{0, 0, 0, 0}, obj = 0, best = 0, best_idx = 0;
    int unsigned col = 0, row = 0, slot = 0, lvl = 0;

    function automatic int unsigned grid_dim(int unsigned sh);
        int unsigned g;
        g = 0;
        if (lvl < 3) g = 32'((grid_reg >> (16 * lvl + sh)) & 64'hFF);
        return (g == 0) ? 1 : g;
    endfunction

    function automatic longint centre_q4(int unsigned raw, int unsigned grid_pos,
                                         int unsigned net, int unsigned g);
        longint t, num, den;
        t = 2 * longint'(raw) + (longint'(grid_pos) << 16) - 32768;
        num = t * longint'(net);
        den = longint'(g) * 4096;
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic logic signed [17:0] clamp_edge(longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[17:0];
    endfunction

    function automatic void step_position();
        col++;
        if (col >= grid_dim(0)) begin
            col = 0;
            row++;
            if (row >= grid_dim(8)) begin
                row = 0;
                slot++;
                if (slot >= 3) begin
                    slot = 0;
                    lvl++;
                    if (lvl >= 3) lvl = 0;
                end
            end
        end
    endfunction

    // one accepted element; returns 1 and the detection when a row is kept
    function automatic bit decode_element(logic [15:0] v, bit fs, output detection_t d);
        int unsigned nc, last, e, sc;
        longint unsigned pair, bw2, bh2, pw, ph;
        longint px, py, hw, hh, wq, hq;
        d = '{default: '0};
        nc = nc_reg;
        if (nc == 0) nc = 1;
        if (nc > 128) nc = 128;
        last = nc + 4;
        if (fs) begin
            elem_idx = 0;
            col = 0; row = 0; slot = 0; lvl = 0;
        end
        e = (elem_idx > last) ? last : elem_idx;
        if (e < 4) box_raw[e] = 32'(v);
        else if (e == 4) obj = 32'(v);
        else if (e == 5) begin
            best = 32'(v);
            best_idx = 0;
        end else if (v > best) begin
            best = 32'(v);
            best_idx = (e - 5) & 7'h7F;
        end
        if (e < last) begin
            elem_idx = e + 1;
            return 1'b0;
        end
        elem_idx = 0;
        sc = 32'((longint'(obj) * best) >> 16);
        if (sc < thr_reg) begin
            step_position();
            return 1'b0;
        end
        px = centre_q4(box_raw[0], col, netw_reg, grid_dim(0));
        py = centre_q4(box_raw[1], row, neth_reg, grid_dim(8));
        pair = (lvl < 3) ? (anc_reg[lvl] >> (20 * slot)) & 20'hFFFFF : 0;
        bw2 = 2 * longint'(box_raw[2]);
        bh2 = 2 * longint'(box_raw[3]);
        pw = bw2 * bw2 * (pair & 10'h3FF);
        ph = bh2 * bh2 * ((pair >> 10) & 10'h3FF);
        wq = pw >> 28;
        hq = ph >> 28;
        hw = pw >> 29;
        hh = ph >> 29;
        if (wq > 131071) wq = 131071;
        if (hq > 131071) hq = 131071;
        d.class_id   = best_idx[6:0];
        d.score      = sc[15:0];
        d.x_min      = clamp_edge(px - hw);
        d.y_min      = clamp_edge(py - hh);
        d.box_width  = wq[16:0];
        d.box_height = hq[16:0];
        d.x_max      = clamp_edge(px + hw);
        d.y_max      = clamp_edge(py + hh);
        step_position();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_element(logic [15:0] v, bit fs);
        int gap;
        detection_t d;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        if (decode_element(v, fs, d)) pending_dets.insert(pending_dets.size(), d);
    endtask

    task automatic write_regs(logic [63:0] vals[8]);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (i[2:0])
                REG_NUM_CLASSES:     nc_reg   = 32'(vals[i][7:0]);
                REG_SCORE_THRESHOLD: thr_reg  = 32'(vals[i][15:0]);
                REG_NET_WIDTH:       netw_reg = 32'(vals[i][11:0]);
                REG_NET_HEIGHT:      neth_reg = 32'(vals[i][11:0]);
                REG_GRID_DIMS:       grid_reg = 64'(vals[i][47:0]);
                REG_ANCHORS_LEVEL0:  anc_reg[0] = 64'(vals[i][59:0]);
                REG_ANCHORS_LEVEL1:  anc_reg[1] = 64'(vals[i][59:0]);
                REG_ANCHORS_LEVEL2:  anc_reg[2] = 64'(vals[i][59:0]);
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver stalls
    int stall_left = 0;
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) < 3) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check
    always @(posedge aclk) begin
        detection_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.class_id   = m_tdata[6:0];
            got.score      = m_tdata[22:7];
            got.x_min      = m_tdata[40:23];
            got.y_min      = m_tdata[58:41];
            got.box_width  = m_tdata[75:59];
            got.box_height = m_tdata[92:76];
            got.x_max      = m_tdata[110:93];
            got.y_max      = m_tdata[128:111];
            if (pending_dets.size() == 0) begin
                $error("detection with none expected");
                fail_count++;
            end else begin
                want = pending_dets.pop_front();
                if (got.class_id !== want.class_id) begin
                    $error("class_id exp %0d got %0d", want.class_id, got.class_id);
                    fail_count++;
                end
                if (got.score !== want.score) begin
                    $error("score exp %0d got %0d", want.score, got.score);
                    fail_count++;
                end
                if (got.x_min !== want.x_min) begin
                    $error("x_min exp %0d got %0d", want.x_min, got.x_min);
                    fail_count++;
                end
                if (got.y_min !== want.y_min) begin
                    $error("y_min exp %0d got %0d", want.y_min, got.y_min);
                    fail_count++;
                end
                if (got.box_width !== want.box_width) begin
                    $error("box_width exp %0d got %0d", want.box_width, got.box_width);
                    fail_count++;
                end
                if (got.box_height !== want.box_height) begin
                    $error("box_height exp %0d got %0d", want.box_height, got.box_height);
                    fail_count++;
                end
                if (got.x_max !== want.x_max) begin
                    $error("x_max exp %0d got %0d", want.x_max, got.x_max);
                    fail_count++;
                end
                if (got.y_max !== want.y_max) begin
                    $error("y_max exp %0d got %0d", want.y_max, got.y_max);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL detection_head_box_decode");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    stim_row_t directed[30] = '{
        '{16'h0000, 1, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0},
        '{16'h0000, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0},
        '{16'hFFFF, 0, 1, 7'd0, 16'd65534},
        '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0},
        '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0},
        '{16'h8000, 0, 1, 7'd1, 16'd32767},
        '{16'h8000, 0, 0, 0, 0}, '{16'h8000, 0, 0, 0, 0}, '{16'h1234, 0, 0, 0, 0},
        '{16'h4321, 0, 0, 0, 0}, '{16'h4000, 0, 0, 0, 0}, '{16'h4000, 0, 0, 0, 0},
        '{16'h0000, 0, 0, 0, 0},
        '{16'h1234, 0, 0, 0, 0}, '{16'h5678, 0, 0, 0, 0},
        '{16'hA5A5, 1, 0, 0, 0}, '{16'h5A5A, 0, 0, 0, 0}, '{16'h7FFF, 0, 0, 0, 0},
        '{16'hC000, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFE, 0, 0, 0, 0},
        '{16'hFFFF, 0, 1, 7'd1, 16'd65534}
    };

    function automatic logic [63:0] pick(logic [63:0] lo, logic [63:0] hi, logic [63:0] rnd);
        int r;
        r = $urandom_range(0, 3);
        return (r == 0) ? lo : (r == 1) ? hi : rnd;
    endfunction

    initial begin
        logic [63:0] regs[8];
        logic [47:0] gd;
        int sent, nc;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        regs = '{64'd2, 64'd16384, 64'd640, 64'd480, 64'd0,
                 {4'h0, {60{1'b1}}}, 64'h0_0C8_0640_0320_01F4, 64'd0};
        write_regs(regs);
        foreach (directed[i]) begin
            send_element(directed[i].value, directed[i].fs);
            if (directed[i].known && pending_dets.size() != 0) begin
                pending_dets[$].class_id = directed[i].k_class;
                pending_dets[$].score    = directed[i].k_score;
            end
        end
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            quiet = (p == 3);
            case (p)
                0: nc = 0;
                1: nc = 128;
                2: nc = 255;
                default: nc = $urandom_range(1, 8);
            endcase
            for (int b = 0; b < 6; b++)
                gd[8*b +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 3));
            if (p == 4) gd = '1;
            regs[0] = 64'(nc);
            regs[1] = (p == 5) ? 64'd65535 : (p == 6) ? 64'd0
                                                      : 64'($urandom_range(0, 40000));
            regs[2] = pick(64'd1, 64'd4095, 64'($urandom_range(1, 4095)));
            regs[3] = pick(64'd1, 64'd4095, 64'($urandom_range(1, 4095)));
            regs[4] = 64'(gd);
            for (int a = 5; a < 8; a++)
                regs[a] = pick(64'd0, {4'h0, {60{1'b1}}},
                               {4'h0, 28'($urandom), 32'($urandom)});
            write_regs(regs);
            sent = 0;
            while (sent < 50) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_element(16'($urandom), 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    int rl;
                    rl = ((nc == 0) ? 1 : (nc > 128) ? 128 : nc) + 5;
                    for (int k = 0; k < rl; k++) begin
                        logic [15:0] v;
                        v = (k == 4) ? 16'($urandom_range(32768, 65535)) : 16'($urandom);
                        send_element(v, (k == 0) && ($urandom_range(0, 7) == 0));
                        sent++;
                    end
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("PASS detection_head_box_decode");
        end else begin
            $display("FAIL detection_head_box_decode");
        end
        $finish;
    end

endmodule

FILE: detection_head_box_decode.f
sv/dhbd_pkg.sv
sv/detection_head_box_decode.sv
tb/testbench.sv
